// ===== rtl/core/dmm_pkg.sv =====
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types and codes for the dense matrix multiply block: command codes,
// register indexes, fixed-point widths and the controller-to-datapath bundle.
// ----------------------------------------------------------------------------
package dmm_pkg;

  // default and widest supported matrix dimension
  localparam int MAX_DIM_DEF = 8;

  // fixed field widths
  localparam int ELEM_W = 16;
  localparam int RES_W  = 32;
  localparam int IDX_W  = 3;
  localparam int DIM_W  = 4;
  localparam int CMD_W  = 2;
  localparam int CFG_IDX_W = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

  // saturation limits of the Q16.16 result
  localparam logic [RES_W-1:0] RES_MAX = 32'h7fff_ffff;
  localparam logic [RES_W-1:0] RES_MIN = 32'h8000_0000;

  // tag that travels with each dot-product step down the datapath
  typedef struct packed {
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } dmm_tag_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     wr_a;
    logic     wr_b;
    logic     rd_en;
    dmm_tag_t tag;
  } dmm_ctl_t;

endpackage

// ===== rtl/core/dmm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmm_ctrl
// Controller: configuration registers, command decode, and the row, column
// and inner-index sequencer that issues one store read per cycle.
// ----------------------------------------------------------------------------
module dmm_ctrl #(
  parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF,
  parameter int AW      = 6
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [dmm_pkg::CMD_W-1:0]      cmd,
  input  logic [dmm_pkg::IDX_W-1:0]      elem_row,
  input  logic [dmm_pkg::IDX_W-1:0]      elem_col,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dmm_pkg::DIM_W-1:0]      cfg_data,
  output dmm_pkg::dmm_ctl_t              ctl,
  output logic [AW-1:0]                  wr_addr,
  output logic [AW-1:0]                  rd_addr_a,
  output logic [AW-1:0]                  rd_addr_b,
  input  logic                           pipe_active
);
  import dmm_pkg::*;

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam logic [DIM_W-1:0] MAX_D4 = DIM_W'(MAX_DIM);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;

  logic [DIM_W-1:0] num_rows, inner_len, num_cols;
  logic [IW-1:0]    nr_m1, nk_m1, nc_m1;
  logic [IW-1:0]    i_cnt, j_cnt, k_cnt;
  logic             accept, in_range, go, last_k, last_elem;

  // dimension minus one, with zero taken as one and large values clamped
  function automatic logic [IW-1:0] dim_m1(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] d;
    if (v == '0) begin
      d = '0;
    end else if (v > MAX_D4) begin
      d = MAX_D4 - DIM_W'(1);
    end else begin
      d = v - DIM_W'(1);
    end
    return d[IW-1:0];
  endfunction

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows  <= DIM_RESET;
      inner_len <= DIM_RESET;
      num_cols  <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_ROWS:  num_rows  <= cfg_data;
        CFG_INNER_LEN: inner_len <= cfg_data;
        CFG_NUM_COLS:  num_cols  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word decode
  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = ({1'b0, elem_row} < MAX_D4) && ({1'b0, elem_col} < MAX_D4);
  assign go       = accept && (cmd == CMD_START);
  assign wr_addr  = AW'(elem_row) * AW'(MAX_DIM) + AW'(elem_col);

  // sequencer flags and store addresses
  assign last_k    = (k_cnt == nk_m1);
  assign last_elem = last_k && (i_cnt == nr_m1) && (j_cnt == nc_m1);
  assign rd_addr_a = AW'(i_cnt) * AW'(MAX_DIM) + AW'(k_cnt);
  assign rd_addr_b = AW'(k_cnt) * AW'(MAX_DIM) + AW'(j_cnt);

  always_comb begin
    ctl               = '0;
    ctl.wr_a          = accept && (cmd == CMD_WRITE_A) && in_range;
    ctl.wr_b          = accept && (cmd == CMD_WRITE_B) && in_range;
    ctl.rd_en         = (state == ST_RUN);
    ctl.tag.first     = (k_cnt == '0);
    ctl.tag.last_k    = last_k;
    ctl.tag.last_elem = last_elem;
    ctl.tag.row       = IDX_W'(i_cnt);
    ctl.tag.col       = IDX_W'(j_cnt);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (go) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (last_elem) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pipe_active) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // loop counters, inner index fastest, then column, then row
  always_ff @(posedge clk) begin
    if (rst) begin
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
    end else if (go) begin
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
    end else if (state == ST_RUN) begin
      if (!last_k) begin
        k_cnt <= k_cnt + IW'(1);
      end else begin
        k_cnt <= '0;
        if (j_cnt != nc_m1) begin
          j_cnt <= j_cnt + IW'(1);
        end else begin
          j_cnt <= '0;
          i_cnt <= i_cnt + IW'(1);
        end
      end
    end
  end

  // dimensions latched for the run
  always_ff @(posedge clk) begin
    if (go) begin
      nr_m1 <= dim_m1(num_rows);
      nk_m1 <= dim_m1(inner_len);
      nc_m1 <= dim_m1(num_cols);
    end
  end

endmodule

// ===== rtl/core/dmm_datapath.sv =====
// ----------------------------------------------------------------------------
// dmm_datapath
// Datapath: the A and B element stores, a registered read stage, a
// registered multiplier and a wide accumulator with Q16.16 saturation.
// ----------------------------------------------------------------------------
module dmm_datapath #(
  parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF,
  parameter int AW      = 6
) (
  input  logic                              clk,
  input  logic                              rst,
  input  dmm_pkg::dmm_ctl_t                 ctl,
  input  logic [AW-1:0]                     wr_addr,
  input  logic [AW-1:0]                     rd_addr_a,
  input  logic [AW-1:0]                     rd_addr_b,
  input  logic signed [dmm_pkg::ELEM_W-1:0] elem_value,
  output logic                              pipe_active,
  output logic                              result_valid,
  output logic signed [dmm_pkg::RES_W-1:0]  product_value,
  output logic [dmm_pkg::IDX_W-1:0]         out_row,
  output logic [dmm_pkg::IDX_W-1:0]         out_col,
  output logic                              last_elem
);
  import dmm_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int PROD_W = 2 * ELEM_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;

  logic signed [ELEM_W-1:0] a_mem [DEPTH];
  logic signed [ELEM_W-1:0] b_mem [DEPTH];

  logic signed [ELEM_W-1:0] a_rd, b_rd;
  logic                     v0, v1;
  dmm_tag_t                 tag0, tag1;
  logic signed [PROD_W-1:0] prod1;
  logic signed [ACC_W-1:0]  acc, sum;
  logic                     fits;

  // element stores, written by write words and read by the sequencer
  always_ff @(posedge clk) begin
    if (ctl.wr_a) a_mem[wr_addr] <= elem_value;
    if (ctl.wr_b) b_mem[wr_addr] <= elem_value;
    if (ctl.rd_en) begin
      a_rd <= a_mem[rd_addr_a];
      b_rd <= b_mem[rd_addr_b];
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= ctl.rd_en;
      v1 <= v0;
    end
  end

  assign pipe_active = v0 || v1;

  // tags and product
  always_ff @(posedge clk) begin
    tag0  <= ctl.tag;
    tag1  <= tag0;
    prod1 <= a_rd * b_rd;
  end

  // accumulate, restarting on the first step of each dot product
  assign sum  = (tag1.first ? ACC_W'(0) : acc) + ACC_W'(prod1);
  assign fits = (&sum[ACC_W-1:RES_W-1]) || !(|sum[ACC_W-1:RES_W-1]);

  always_ff @(posedge clk) begin
    if (v1) acc <= sum;
  end

  // result register, saturated to Q16.16
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= v1 && tag1.last_k;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && tag1.last_k) begin
      if (fits) begin
        product_value <= sum[RES_W-1:0];
      end else begin
        product_value <= sum[ACC_W-1] ? RES_MIN : RES_MAX;
      end
      out_row   <= tag1.row;
      out_col   <= tag1.col;
      last_elem <= tag1.last_elem;
    end
  end

endmodule

// ===== rtl/core/dense_matrix_multiply.sv =====
// ----------------------------------------------------------------------------
// dense_matrix_multiply
// C = A * B on signed Q8.8 elements with a saturated Q16.16 result.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Write words (A or B
// element) leave busy low, so they can stream one per cycle while no run is
// in progress. A start word runs the sequencer through num_rows * num_cols *
// inner_len store reads, one per cycle, set by the single read port of each
// element store; busy stays high until the read, multiply and accumulate
// stages have drained. Results come out in row-major order, each held for
// one cycle under result_valid, with last_elem on the final one. The receiver
// cannot stall: every result must be taken in the cycle it is shown. The
// user must write configuration only while busy is low; it is not enforced.
module dense_matrix_multiply #(
  parameter int MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [dmm_pkg::CMD_W-1:0]         cmd,
  input  logic [dmm_pkg::IDX_W-1:0]         elem_row,
  input  logic [dmm_pkg::IDX_W-1:0]         elem_col,
  input  logic signed [dmm_pkg::ELEM_W-1:0] elem_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dmm_pkg::DIM_W-1:0]         cfg_data,
  output logic                              result_valid,
  output logic signed [dmm_pkg::RES_W-1:0]  product_value,
  output logic [dmm_pkg::IDX_W-1:0]         out_row,
  output logic [dmm_pkg::IDX_W-1:0]         out_col,
  output logic                              last_elem
);
  import dmm_pkg::*;

  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  dmm_ctl_t      ctl;
  logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic          pipe_active;

  // sequencer and configuration
  dmm_ctrl #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .elem_row    (elem_row),
    .elem_col    (elem_col),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ctl         (ctl),
    .wr_addr     (wr_addr),
    .rd_addr_a   (rd_addr_a),
    .rd_addr_b   (rd_addr_b),
    .pipe_active (pipe_active)
  );

  // stores, multiplier and accumulator
  dmm_datapath #(
    .MAX_DIM (MAX_DIM),
    .AW      (AW)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .wr_addr       (wr_addr),
    .rd_addr_a     (rd_addr_a),
    .rd_addr_b     (rd_addr_b),
    .elem_value    (elem_value),
    .pipe_active   (pipe_active),
    .result_valid  (result_valid),
    .product_value (product_value),
    .out_row       (out_row),
    .out_col       (out_col),
    .last_elem     (last_elem)
  );

  // results only come out of a run in progress
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result word outside a run");

  // the final result of a run is not followed at once by another
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_elem |=> !result_valid)
    else $error("result word right after the last of a run");

  // while results remain, the block still reports busy
  a_busy_until_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_elem |-> busy)
    else $error("busy dropped before the last result word");

endmodule

// ===== tb/sv/dense_matrix_multiply_test.sv =====
// ----------------------------------------------------------------------------
// dense_matrix_multiply_test
// Self-checking bench for the dense matrix multiply block. A queue of
// element writes, start words and register writes feeds a clocked driver.
// The driver leaves random gaps between words and sends register writes only
// once the block has gone quiet. A clocked monitor keeps its own copy of the
// A and B stores and the dimensions. It predicts every C element of each
// start and checks the results in order.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_test;
  import dmm_pkg::*;

  localparam int MAX_DIM = 8;
  localparam int ITEMS = 250;
  localparam int SETTLE = 8;
  localparam int DRAIN = 16;
  localparam int LIMIT_TIME = 2000000;
  localparam int REPORT_MAX = 10;

  // codes the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // one pending word: either a block word or a register write
  typedef struct {
    bit                    is_reg;
    logic [CMD_W-1:0]      cmd;
    logic [IDX_W-1:0]      row;
    logic [IDX_W-1:0]      col;
    logic [ELEM_W-1:0]     value;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [DIM_W-1:0]      reg_data;
  } word_t;

  // one C element
  typedef struct {
    logic signed [RES_W-1:0] value;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
  } product_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0] cmd = CMD_WRITE_A;
  logic [IDX_W-1:0] elem_row = '0;
  logic [IDX_W-1:0] elem_col = '0;
  logic signed [ELEM_W-1:0] elem_value = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NUM_ROWS;
  logic [DIM_W-1:0] cfg_data = '0;
  logic result_valid;
  logic signed [RES_W-1:0] product_value;
  logic [IDX_W-1:0] out_row;
  logic [IDX_W-1:0] out_col;
  logic last_elem;

  dense_matrix_multiply #(
    .MAX_DIM(MAX_DIM)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .elem_row(elem_row),
    .elem_col(elem_col),
    .elem_value(elem_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .result_valid(result_valid),
    .product_value(product_value),
    .out_row(out_row),
    .out_col(out_col),
    .last_elem(last_elem)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  word_t word_fifo[$];
  product_t product_fifo[$];

  // predictor copy of the block state
  logic signed [ELEM_W-1:0] a_mem [0:MAX_DIM*MAX_DIM-1];
  logic signed [ELEM_W-1:0] b_mem [0:MAX_DIM*MAX_DIM-1];
  logic [DIM_W-1:0] dim_rows = DIM_RESET;
  logic [DIM_W-1:0] dim_inner = DIM_RESET;
  logic [DIM_W-1:0] dim_cols = DIM_RESET;

  // handshake flags passed from monitor to driver
  bit word_taken = 1'b0;
  bit reg_taken = 1'b0;
  int idle_run = 0;
  int gap_left = 0;
  int burst_left = 0;
  int error_count = 0;

  // generator view: planned dimensions and entries written so far
  logic [DIM_W-1:0] plan_dim [0:2];
  bit a_written [0:MAX_DIM*MAX_DIM-1];
  bit b_written [0:MAX_DIM*MAX_DIM-1];
  int item_count = 0;

  // a register value of 0 acts as 1, anything above the store size as the size
  function automatic int eff_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  // element values lean toward the extremes
  function automatic logic [ELEM_W-1:0] rand_elem();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    if (r == 2) return 16'h0000;
    return ELEM_W'($urandom);
  endfunction

  // dimensions mostly small, with the edge codes now and then
  function automatic logic [DIM_W-1:0] rand_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5) return DIM_W'($urandom_range(1, 4));
    if (r == 6) return 4'd0;
    if (r == 7) return 4'd8;
    if (r == 8) return 4'd15;
    return DIM_W'($urandom_range(0, 15));
  endfunction

  // gap after a word: mostly none or short, a few long, with gapless bursts
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      burst_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_word(logic [CMD_W-1:0] c, logic [IDX_W-1:0] r,
                            logic [IDX_W-1:0] k, logic [ELEM_W-1:0] v);
    word_t w;
    w = '{is_reg: 1'b0, cmd: c, row: r, col: k, value: v,
          reg_idx: CFG_UNUSED, reg_data: '0};
    word_fifo.push_back(w);
    if (c != CMD_UNUSED) item_count++;
    if (c == CMD_WRITE_A) a_written[{r, k}] = 1'b1;
    if (c == CMD_WRITE_B) b_written[{r, k}] = 1'b1;
  endtask

  task automatic queue_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] d);
    word_t w;
    w = '{is_reg: 1'b1, cmd: CMD_UNUSED, row: '0, col: '0, value: '0,
          reg_idx: idx, reg_data: d};
    word_fifo.push_back(w);
    if (idx != CFG_UNUSED) plan_dim[idx] = d;
  endtask

  // fill every entry the run will read that is still unwritten, then start
  task automatic queue_start();
    int nr, nk, nc;
    nr = eff_dim(plan_dim[CFG_NUM_ROWS]);
    nk = eff_dim(plan_dim[CFG_INNER_LEN]);
    nc = eff_dim(plan_dim[CFG_NUM_COLS]);
    for (int i = 0; i < nr; i++)
      for (int k = 0; k < nk; k++)
        if (!a_written[i*MAX_DIM+k])
          queue_word(CMD_WRITE_A, IDX_W'(i), IDX_W'(k), rand_elem());
    for (int k = 0; k < nk; k++)
      for (int j = 0; j < nc; j++)
        if (!b_written[k*MAX_DIM+j])
          queue_word(CMD_WRITE_B, IDX_W'(k), IDX_W'(j), rand_elem());
    queue_word(CMD_START, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
  endtask

  // expected C elements of one start, row-major, saturated to Q16.16
  task automatic compute_products();
    int nr, nk, nc;
    longint acc;
    product_t p;
    nr = eff_dim(dim_rows);
    nk = eff_dim(dim_inner);
    nc = eff_dim(dim_cols);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        acc = 0;
        for (int k = 0; k < nk; k++)
          acc += longint'(a_mem[i*MAX_DIM+k]) * longint'(b_mem[k*MAX_DIM+j]);
        if (acc > 64'sd2147483647) p.value = RES_MAX;
        else if (acc < -64'sd2147483648) p.value = RES_MIN;
        else p.value = acc[RES_W-1:0];
        p.row = IDX_W'(i);
        p.col = IDX_W'(j);
        p.last = (i == nr - 1) && (j == nc - 1);
        product_fifo.push_back(p);
      end
    end
  endtask

  task automatic flag_error(string msg);
    error_count++;
    if (error_count <= REPORT_MAX) $display("ERROR: %s", msg);
  endtask

  // monitor: accept words and register writes, check results
  always @(posedge clk) begin : monitor
    product_t exp_p;
    if (rst) begin
      dim_rows = DIM_RESET;
      dim_inner = DIM_RESET;
      dim_cols = DIM_RESET;
      idle_run = 0;
    end else begin
      // results first, so a start taken at this edge cannot match them
      if (result_valid) begin
        if (product_fifo.size() == 0) begin
          flag_error($sformatf("unexpected result value=%0d row=%0d col=%0d last=%0b",
                               product_value, out_row, out_col, last_elem));
        end else begin
          exp_p = product_fifo.pop_front();
          if (product_value !== exp_p.value || out_row !== exp_p.row ||
              out_col !== exp_p.col || last_elem !== exp_p.last)
            flag_error($sformatf(
              "expected value=%0d row=%0d col=%0d last=%0b, got value=%0d row=%0d col=%0d last=%0b",
              exp_p.value, exp_p.row, exp_p.col, exp_p.last,
              product_value, out_row, out_col, last_elem));
        end
      end
      // word accepted
      if (start && !busy) begin
        word_taken = 1'b1;
        case (cmd)
          CMD_WRITE_A: a_mem[{elem_row, elem_col}] = elem_value;
          CMD_WRITE_B: b_mem[{elem_row, elem_col}] = elem_value;
          CMD_START:   compute_products();
          default: ;
        endcase
      end
      // register write accepted
      if (cfg_valid && cfg_ready) begin
        reg_taken = 1'b1;
        case (cfg_index)
          CFG_NUM_ROWS:  dim_rows = cfg_data;
          CFG_INNER_LEN: dim_inner = cfg_data;
          CFG_NUM_COLS:  dim_cols = cfg_data;
          default: ;
        endcase
      end
      // quiet time before a register write may go out
      if (!busy && !start && product_fifo.size() == 0) begin
        if (idle_run < SETTLE) idle_run++;
      end else begin
        idle_run = 0;
      end
    end
  end

  // driver: present queued words at the falling edge
  always @(negedge clk) begin : driver
    logic nxt_start, nxt_cfg;
    word_t cur;
    nxt_start = start;
    nxt_cfg = cfg_valid;
    if (rst) begin
      nxt_start = 1'b0;
      nxt_cfg = 1'b0;
      word_taken = 1'b0;
      reg_taken = 1'b0;
    end else begin
      if (word_taken) begin
        word_taken = 1'b0;
        nxt_start = 1'b0;
      end
      if (reg_taken) begin
        reg_taken = 1'b0;
        nxt_cfg = 1'b0;
      end
      if (!nxt_start && !nxt_cfg) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (word_fifo.size() > 0 &&
                     (!word_fifo[0].is_reg || idle_run >= SETTLE)) begin
          cur = word_fifo.pop_front();
          if (cur.is_reg) begin
            cfg_index <= cur.reg_idx;
            cfg_data <= cur.reg_data;
            nxt_cfg = 1'b1;
          end else begin
            cmd <= cur.cmd;
            elem_row <= cur.row;
            elem_col <= cur.col;
            elem_value <= cur.value;
            nxt_start = 1'b1;
          end
          gap_left = pick_gap();
        end
      end
    end
    start <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  // stimulus and end of run
  initial begin : stimulus
    int n;
    logic [CMD_W-1:0] wc;
    int nr, nk, nc;
    logic [IDX_W-1:0] wr, wk;
    for (int i = 0; i < MAX_DIM*MAX_DIM; i++) begin
      a_written[i] = 1'b0;
      b_written[i] = 1'b0;
    end
    for (int i = 0; i < 3; i++) plan_dim[i] = DIM_RESET;

    // zero dimensions act as one: a single product of the largest values
    queue_reg(CFG_NUM_ROWS, 4'd0);
    queue_reg(CFG_INNER_LEN, 4'd0);
    queue_reg(CFG_NUM_COLS, 4'd0);
    queue_word(CMD_WRITE_A, 3'd0, 3'd0, 16'h7fff);
    queue_word(CMD_WRITE_B, 3'd0, 3'd0, 16'h7fff);
    queue_start();
    // unused command is ignored
    queue_word(CMD_UNUSED, 3'd7, 3'd7, 16'hffff);
    // inner length above the store size, most negative values: positive overflow
    queue_reg(CFG_INNER_LEN, 4'd15);
    for (int k = 0; k < MAX_DIM; k++) begin
      queue_word(CMD_WRITE_A, 3'd0, IDX_W'(k), 16'h8000);
      queue_word(CMD_WRITE_B, IDX_W'(k), 3'd0, 16'h8000);
    end
    queue_start();
    // mixed signs: negative overflow, reusing the stale A row
    for (int k = 0; k < MAX_DIM; k++)
      queue_word(CMD_WRITE_B, IDX_W'(k), 3'd0, 16'h7fff);
    queue_start();
    // one run at full size, then back to small
    queue_reg(CFG_NUM_ROWS, 4'd8);
    queue_reg(CFG_NUM_COLS, 4'd15);
    queue_start();
    queue_reg(CFG_NUM_ROWS, 4'd2);
    queue_reg(CFG_INNER_LEN, 4'd1);
    queue_reg(CFG_NUM_COLS, 4'd2);
    queue_reg(CFG_UNUSED, 4'd5);

    // random phases: optional reconfig, some writes and noise, then a start
    while (item_count < ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1)) queue_reg(CFG_NUM_ROWS, rand_dim());
        if ($urandom_range(0, 1)) queue_reg(CFG_INNER_LEN, rand_dim());
        if ($urandom_range(0, 1)) queue_reg(CFG_NUM_COLS, rand_dim());
        if ($urandom_range(0, 7) == 0) queue_reg(CFG_UNUSED, DIM_W'($urandom));
      end
      nr = eff_dim(plan_dim[CFG_NUM_ROWS]);
      nk = eff_dim(plan_dim[CFG_INNER_LEN]);
      nc = eff_dim(plan_dim[CFG_NUM_COLS]);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_word(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
        end else begin
          wc = $urandom_range(0, 1) ? CMD_WRITE_B : CMD_WRITE_A;
          if ($urandom_range(0, 3) == 0) begin
            wr = IDX_W'($urandom);
            wk = IDX_W'($urandom);
          end else if (wc == CMD_WRITE_A) begin
            wr = IDX_W'($urandom_range(0, nr - 1));
            wk = IDX_W'($urandom_range(0, nk - 1));
          end else begin
            wr = IDX_W'($urandom_range(0, nk - 1));
            wk = IDX_W'($urandom_range(0, nc - 1));
          end
          queue_word(wc, wr, wk, rand_elem());
        end
      end
      queue_start();
    end

    // reset once
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for the queue to empty and every result to arrive
    while (word_fifo.size() != 0 || start || cfg_valid) @(posedge clk);
    while (product_fifo.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #LIMIT_TIME;
    $display("Test completed with failures");
    $finish;
  end

endmodule
